FILE: rtl/tipcc_pkg.sv
package tipcc_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_ROBOT_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROBOT_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEELBASE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MARGIN       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CLEAR    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP_FRAC    = 3'd5;

  localparam logic [13:0] ROBOT_LENGTH_RESET = 14'd500;
  localparam logic [13:0] ROBOT_WIDTH_RESET  = 14'd400;
  localparam logic [13:0] WHEELBASE_RESET    = 14'd300;
  localparam logic [11:0] MARGIN_RESET       = 12'd50;
  localparam logic [15:0] MAX_CLEAR_RESET    = 16'd1000;
  localparam logic [7:0]  CLIP_FRAC_RESET    = 8'd26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAD_GO,
    ST_RAD_WAIT,
    ST_PT_GO,
    ST_PT_WAIT,
    ST_EMIT
  } core_state_t;

  typedef enum logic [1:0] {
    RSS_IDLE,
    RSS_MUL,
    RSS_ROOT,
    RSS_DONE
  } rss_phase_t;

  typedef struct packed {
    logic start;
    logic quarter;
  } rss_ctl_t;

endpackage

FILE: rtl/tipcc_if.sv
interface tipcc_point_if #(
  parameter int COORD_BITS = tipcc_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x_mm;
  logic signed [COORD_BITS-1:0] point_y_mm;
  logic                         point_valid;
  logic                         last_point;

  modport source (output valid, point_x_mm, point_y_mm, point_valid, last_point,
                  input ready);
  modport sink (input valid, point_x_mm, point_y_mm, point_valid, last_point,
                output ready);
endinterface

interface tipcc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] clearance_mm;
  logic        collision;

  modport source (output valid, clearance_mm, collision, input ready);
  modport sink (input valid, clearance_mm, collision, output ready);
endinterface

interface tipcc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tipcc_pkg::CFG_INDEX_W-1:0]   index;
  logic [tipcc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/tipcc_rss.sv
module tipcc_rss #(
  parameter int OPW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tipcc_pkg::rss_ctl_t  ctl,
  input  logic [OPW-1:0]       op_a,
  input  logic [OPW-1:0]       op_b,
  output logic                 done,
  output logic [OPW-1:0]       root
);

  localparam int AW    = 2 * OPW;
  localparam int CNT_W = $clog2(OPW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPW - 1);

  tipcc_pkg::rss_phase_t phase, phase_next;

  logic [CNT_W-1:0] cnt;
  logic [OPW-1:0]   a_bits;
  logic [OPW-1:0]   b_bits;
  logic [AW-1:0]    a_sh;
  logic [AW-1:0]    b_sh;
  logic [AW-1:0]    acc;
  logic [OPW-1:0]   rem;
  logic             quarter;

  logic [AW-1:0]    sum;
  logic [OPW+1:0]   rem_sh;
  logic [OPW+1:0]   trial;

  assign sum    = acc + (a_bits[0] ? a_sh : '0) + (b_bits[0] ? b_sh : '0);
  assign rem_sh = {rem, acc[AW-1:AW-2]};
  assign trial  = {root, 2'b01};

  always_comb begin
    phase_next = phase;
    case (phase)
      tipcc_pkg::RSS_IDLE: if (ctl.start) phase_next = tipcc_pkg::RSS_MUL;
      tipcc_pkg::RSS_MUL:  if (cnt == '0) phase_next = tipcc_pkg::RSS_ROOT;
      tipcc_pkg::RSS_ROOT: if (cnt == '0) phase_next = tipcc_pkg::RSS_DONE;
      tipcc_pkg::RSS_DONE: phase_next = tipcc_pkg::RSS_IDLE;
      default:             phase_next = tipcc_pkg::RSS_IDLE;
    endcase
  end

  always_comb begin
    done = (phase == tipcc_pkg::RSS_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tipcc_pkg::RSS_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      tipcc_pkg::RSS_IDLE: begin
        if (ctl.start) begin
          a_bits  <= op_a;
          b_bits  <= op_b;
          a_sh    <= AW'(op_a);
          b_sh    <= AW'(op_b);
          acc     <= '0;
          cnt     <= CNT_LAST;
          quarter <= ctl.quarter;
        end
      end
      tipcc_pkg::RSS_MUL: begin
        a_bits <= a_bits >> 1;
        b_bits <= b_bits >> 1;
        a_sh   <= a_sh << 1;
        b_sh   <= b_sh << 1;
        if (cnt == '0) begin
          acc  <= quarter ? (sum >> 2) : sum;
          cnt  <= CNT_LAST;
          rem  <= '0;
          root <= '0;
        end else begin
          acc <= sum;
          cnt <= cnt - 1'b1;
        end
      end
      tipcc_pkg::RSS_ROOT: begin
        acc <= acc << 2;
        cnt <= cnt - 1'b1;
        if (rem_sh >= trial) begin
          rem  <= OPW'(rem_sh - trial);
          root <= {root[OPW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[OPW-1:0];
          root <= {root[OPW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/turn_in_place_clearance_check_core.sv
// A point item, until its scan collides, holds the core while the shared bit-serial
// squarer and root unit, W = max(COORD_BITS, 16) bits wide, finds its distance.
// The first item of a scan also waits for the swept radius, and the last item
// also loads the result register.
// Reset is synchronous and active high: the configuration registers return to their
// defaults, no scan is open and no result is pending.
module turn_in_place_clearance_check_core #(
  parameter int COORD_BITS = tipcc_pkg::COORD_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  tipcc_cfg_if.sink      cfg,
  tipcc_point_if.sink    points,
  tipcc_result_if.source result
);

  localparam int OPW = (COORD_BITS > 16) ? COORD_BITS : 16;

  logic [13:0] body_length;
  logic [13:0] body_width;
  logic [13:0] wheelbase;
  logic [11:0] margin;
  logic [15:0] max_clear;
  logic [7:0]  clip_frac;

  tipcc_pkg::core_state_t state, state_next;

  logic [OPW-1:0] mag_x;
  logic [OPW-1:0] mag_y;
  logic           pt_valid;
  logic           pt_last;
  logic [OPW-1:0] radius;
  logic [15:0]    running;
  logic           collided;
  logic           scan_open;
  logic           out_valid;
  logic [15:0]    out_clear;
  logic           out_coll;

  logic           in_acc;
  logic           emit_go;
  logic           rss_done;
  logic [OPW-1:0] rss_root;
  tipcc_pkg::rss_ctl_t rss_ctl;
  logic [OPW-1:0] op_a;
  logic [OPW-1:0] op_b;

  logic [COORD_BITS-1:0] abs_x;
  logic [COORD_BITS-1:0] abs_y;
  logic [14:0] len_g;
  logic [14:0] wid_g;
  logic [15:0] len_sum;
  logic [14:0] len_front;
  logic [14:0] len_rear;
  logic [14:0] len_max;
  logic [15:0] len_max2;
  logic [OPW-1:0] gap;
  logic [23:0] clip_thr;
  logic [15:0] clear_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length  <= tipcc_pkg::ROBOT_LENGTH_RESET;
      body_width   <= tipcc_pkg::ROBOT_WIDTH_RESET;
      wheelbase    <= tipcc_pkg::WHEELBASE_RESET;
      margin       <= tipcc_pkg::MARGIN_RESET;
      max_clear    <= tipcc_pkg::MAX_CLEAR_RESET;
      clip_frac    <= tipcc_pkg::CLIP_FRAC_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tipcc_pkg::REG_ROBOT_LENGTH: body_length  <= cfg.data[13:0];
        tipcc_pkg::REG_ROBOT_WIDTH:  body_width   <= cfg.data[13:0];
        tipcc_pkg::REG_WHEELBASE:    wheelbase    <= cfg.data[13:0];
        tipcc_pkg::REG_MARGIN:       margin       <= cfg.data[11:0];
        tipcc_pkg::REG_MAX_CLEAR:    max_clear    <= cfg.data[15:0];
        tipcc_pkg::REG_CLIP_FRAC:    clip_frac    <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The swept footprint: grown length and width, and the longer of front and rear.
  assign len_g     = 15'(body_length) + {2'b00, margin, 1'b0};
  assign wid_g     = 15'(body_width) + {2'b00, margin, 1'b0};
  assign len_sum   = 16'(len_g) + 16'(wheelbase);
  assign len_front = 15'(len_sum >> 1);
  assign len_rear  = len_g - len_front;
  assign len_max   = ((len_g >= len_front) && (len_rear > len_front)) ? len_rear : len_front;
  assign len_max2  = {len_max, 1'b0};

  assign abs_x = points.point_x_mm[COORD_BITS-1] ? (-points.point_x_mm) : points.point_x_mm;
  assign abs_y = points.point_y_mm[COORD_BITS-1] ? (-points.point_y_mm) : points.point_y_mm;

  assign in_acc = points.valid & points.ready;

  always_comb begin
    rss_ctl.start   = (state == tipcc_pkg::ST_RAD_GO) || (state == tipcc_pkg::ST_PT_GO);
    rss_ctl.quarter = (state == tipcc_pkg::ST_RAD_GO);
    op_a            = (state == tipcc_pkg::ST_RAD_GO) ? OPW'(len_max2) : mag_x;
    op_b            = (state == tipcc_pkg::ST_RAD_GO) ? OPW'(wid_g) : mag_y;
  end

  tipcc_rss #(
    .OPW (OPW)
  ) u_rss (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rss_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .done (rss_done),
    .root (rss_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      tipcc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!scan_open) begin
            state_next = tipcc_pkg::ST_RAD_GO;
          end else if (points.point_valid && !collided) begin
            state_next = tipcc_pkg::ST_PT_GO;
          end else if (points.last_point) begin
            state_next = tipcc_pkg::ST_EMIT;
          end
        end
      end
      tipcc_pkg::ST_RAD_GO: state_next = tipcc_pkg::ST_RAD_WAIT;
      tipcc_pkg::ST_RAD_WAIT: begin
        if (rss_done) begin
          if (pt_valid) begin
            state_next = tipcc_pkg::ST_PT_GO;
          end else if (pt_last) begin
            state_next = tipcc_pkg::ST_EMIT;
          end else begin
            state_next = tipcc_pkg::ST_IDLE;
          end
        end
      end
      tipcc_pkg::ST_PT_GO: state_next = tipcc_pkg::ST_PT_WAIT;
      tipcc_pkg::ST_PT_WAIT: begin
        if (rss_done) begin
          state_next = pt_last ? tipcc_pkg::ST_EMIT : tipcc_pkg::ST_IDLE;
        end
      end
      tipcc_pkg::ST_EMIT: if (emit_go) state_next = tipcc_pkg::ST_IDLE;
      default: state_next = tipcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    points.ready = (state == tipcc_pkg::ST_IDLE);
    emit_go      = (state == tipcc_pkg::ST_EMIT) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tipcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign gap       = rss_root - radius;
  assign clip_thr  = 24'(clip_frac) * 24'(max_clear);
  assign clear_out = ({running, 8'h00} < clip_thr) ? 16'd0 : running;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_x    <= OPW'(abs_x);
      mag_y    <= OPW'(abs_y);
      pt_valid <= points.point_valid;
      pt_last  <= points.last_point;
    end
    if ((state == tipcc_pkg::ST_RAD_WAIT) && rss_done) begin
      radius <= rss_root;
    end
    if (emit_go) begin
      out_clear <= clear_out;
      out_coll  <= collided;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= tipcc_pkg::MAX_CLEAR_RESET;
      collided  <= 1'b0;
      scan_open <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && !scan_open) begin
        running   <= max_clear;
        collided  <= 1'b0;
        scan_open <= 1'b1;
      end
      if ((state == tipcc_pkg::ST_PT_WAIT) && rss_done) begin
        if (rss_root >= radius) begin
          if (gap < OPW'(running)) begin
            running <= gap[15:0];
          end
        end else begin
          collided <= 1'b1;
          running  <= 16'd0;
        end
      end
      if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
        scan_open <= 1'b0;
        collided  <= 1'b0;
        running   <= max_clear;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.clearance_mm = out_clear;
  assign result.collision    = out_coll;

endmodule

FILE: dv/turn_in_place_clearance_check_core_test.sv
`timescale 1ns / 1ps

module turn_in_place_clearance_check_core_test;

  localparam int CB = tipcc_pkg::COORD_BITS_DEFAULT;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int PHASES = 12;
  localparam int DIRECTED_ROWS = 22;
  localparam logic [tipcc_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [tipcc_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 pvalid;
    logic                 last;
  } point_item_t;

  typedef struct packed {
    logic [15:0] clearance;
    logic        collision;
  } scan_result_t;

  typedef struct packed {
    point_item_t  pt;
    logic         typed;
    scan_result_t res;
  } directed_row_t;

  logic clk;
  logic rst;

  tipcc_cfg_if                       cfg_ch();
  tipcc_point_if #(.COORD_BITS(CB)) point_ch();
  tipcc_result_if                    result_ch();

  turn_in_place_clearance_check_core #(.COORD_BITS(CB)) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .points (point_ch),
    .result (result_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  logic [13:0] fp_length;
  logic [13:0] fp_width;
  logic [13:0] fp_wheelbase;
  logic [11:0] fp_margin;
  logic [15:0] fp_max_clear;
  logic [7:0]  fp_clip;

  logic [15:0]       scan_clear;
  logic              scan_hit;
  longint unsigned   scan_radius;
  logic              scan_open;

  scan_result_t  awaited_results[$];
  directed_row_t directed_rows[DIRECTED_ROWS];
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  logic          row_typed = 1'b0;
  scan_result_t  row_result = '0;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem = v;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned swept_radius_of();
    longint len_v, wid_v, wb_v, mar_v;
    longint l, w, lf, lr, m;
    len_v = fp_length;
    wid_v = fp_width;
    wb_v = fp_wheelbase;
    mar_v = fp_margin;
    l = len_v + 2 * mar_v;
    w = wid_v + 2 * mar_v;
    lf = (l + wb_v) / 2;
    lr = l - lf;
    m = (lf > lr) ? lf : lr;
    return floor_sqrt(longint'(unsigned'(m * m)) + longint'(unsigned'(w * w)) / 4);
  endfunction

  task automatic advance_scan(input point_item_t p);
    longint          sx, sy;
    longint unsigned dist_mm, gap, clr;
    scan_result_t    r;
    if (!scan_open) begin
      scan_clear = fp_max_clear;
      scan_hit = 1'b0;
      scan_radius = swept_radius_of();
      scan_open = 1'b1;
    end
    if (p.pvalid && !scan_hit) begin
      sx = $signed(p.x);
      sy = $signed(p.y);
      dist_mm = floor_sqrt(sx * sx + sy * sy);
      if (dist_mm >= scan_radius) begin
        gap = dist_mm - scan_radius;
        if (gap < scan_clear) scan_clear = gap[15:0];
      end else begin
        scan_hit = 1'b1;
        scan_clear = '0;
      end
    end
    if (p.last) begin
      clr = scan_clear;
      if (clr * 64'd256 < longint'(fp_clip) * longint'(fp_max_clear)) clr = 0;
      r.clearance = clr[15:0];
      r.collision = scan_hit;
      if (row_typed) awaited_results = {awaited_results, row_result};
      else awaited_results = {awaited_results, r};
      scan_open = 1'b0;
      scan_clear = fp_max_clear;
      scan_hit = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    scan_result_t want;
    logic         moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        case (cfg_ch.index)
          tipcc_pkg::REG_ROBOT_LENGTH: fp_length = cfg_ch.data[13:0];
          tipcc_pkg::REG_ROBOT_WIDTH:  fp_width = cfg_ch.data[13:0];
          tipcc_pkg::REG_WHEELBASE:    fp_wheelbase = cfg_ch.data[13:0];
          tipcc_pkg::REG_MARGIN:       fp_margin = cfg_ch.data[11:0];
          tipcc_pkg::REG_MAX_CLEAR:    fp_max_clear = cfg_ch.data;
          tipcc_pkg::REG_CLIP_FRAC:    fp_clip = cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (point_ch.valid && point_ch.ready) begin
        moved = 1'b1;
        advance_scan(point_item_t'{point_ch.point_x_mm, point_ch.point_y_mm,
                                   point_ch.point_valid, point_ch.last_point});
      end
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with nothing awaited", result_ch.clearance_mm, -1);
        end else begin
          want = awaited_results.pop_front();
          if (result_ch.clearance_mm !== want.clearance)
            flag_mismatch("clearance_mm", result_ch.clearance_mm, want.clearance);
          if (result_ch.collision !== want.collision)
            flag_mismatch("collision", result_ch.collision, want.collision);
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    logic [15:0] stall_pattern;
    int          pattern_age;
    int          pos;
    result_ch.ready = 1'b0;
    stall_pattern = '1;
    pattern_age = 0;
    pos = 0;
    forever begin
      @(negedge clk);
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        pattern_age = $urandom_range(16, 96);
      end
      pattern_age--;
      result_ch.ready <= stall_pattern[pos];
      pos = (pos + 1) % 16;
    end
  end

  task automatic send_point(input point_item_t p, input logic typed, input scan_result_t want);
    int gap_len;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap_len = 0;
        1: gap_len = $urandom_range(1, 3);
        2: gap_len = $urandom_range(1, 12);
        default: gap_len = $urandom_range(10, 40);
      endcase
      repeat (gap_len) begin
        @(negedge clk);
        point_ch.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    point_ch.valid <= 1'b1;
    point_ch.point_x_mm <= p.x;
    point_ch.point_y_mm <= p.y;
    point_ch.point_valid <= p.pvalid;
    point_ch.last_point <= p.last;
    row_typed = typed;
    row_result = want;
    do @(posedge clk); while (!point_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    point_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tipcc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [tipcc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_footprint(input logic [13:0] len, input logic [13:0] wid,
                                   input logic [13:0] wb, input logic [11:0] mar,
                                   input logic [15:0] maxc, input logic [7:0] clip);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(tipcc_pkg::REG_ROBOT_LENGTH, {2'($urandom), len});
    write_reg(tipcc_pkg::REG_ROBOT_WIDTH, {2'($urandom), wid});
    write_reg(tipcc_pkg::REG_WHEELBASE, {2'($urandom), wb});
    write_reg(tipcc_pkg::REG_MARGIN, {4'($urandom), mar});
    write_reg(tipcc_pkg::REG_MAX_CLEAR, maxc);
    write_reg(tipcc_pkg::REG_CLIP_FRAC, {8'($urandom), clip});
    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    point_item_t item;
    logic [13:0] len, wid, wb;
    logic [11:0] mar;
    logic [15:0] maxc;
    logic [7:0]  clip;
    int phase, i, k, scan_len, reach, phase_items, scans;
    logic broken;

    rst = 1'b1;
    point_ch.valid = 1'b0;
    point_ch.point_x_mm = '0;
    point_ch.point_y_mm = '0;
    point_ch.point_valid = 1'b0;
    point_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    fp_length = tipcc_pkg::ROBOT_LENGTH_RESET;
    fp_width = tipcc_pkg::ROBOT_WIDTH_RESET;
    fp_wheelbase = tipcc_pkg::WHEELBASE_RESET;
    fp_margin = tipcc_pkg::MARGIN_RESET;
    fp_max_clear = tipcc_pkg::MAX_CLEAR_RESET;
    fp_clip = tipcc_pkg::CLIP_FRAC_RESET;
    scan_open = 1'b0;
    scan_clear = fp_max_clear;
    scan_hit = 1'b0;
    scan_radius = swept_radius_of();
    scans = 0;

    // With the default footprint the swept radius is 514 mm and clearances of
    // 101 mm or less fall inside the dead band.
    directed_rows = '{
      '{'{16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b1, '{16'd1000, 1'b0}},
      '{'{16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b1}},
      '{'{16'sh7FFF, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'd1000, 1'b0}},
      '{'{16'sh8000, 16'sh8000, 1'b1, 1'b1}, 1'b1, '{16'd1000, 1'b0}},
      '{'{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1}, 1'b1, '{16'd1000, 1'b0}},
      '{'{16'sh8000, 16'sh7FFF, 1'b1, 1'b1}, 1'b1, '{16'd1000, 1'b0}},
      '{'{16'sd514, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b0}},
      '{'{16'sd0, -16'sd513, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b1}},
      '{'{-16'sd614, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b0}},
      '{'{16'sd0, 16'sd616, 1'b1, 1'b1}, 1'b1, '{16'd102, 1'b0}},
      '{'{16'sd0, 16'sd615, 1'b1, 1'b1}, 1'b1, '{16'd0, 1'b0}},
      '{'{16'sd800, 16'sd0, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd0, -16'sd700, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{-16'sd600, 16'sd300, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd0, 16'sd0, 1'b0, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd700, 16'sd0, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd400, 16'sd100, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd2000, 16'sd0, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd0, 16'sd0, 1'b0, 1'b1}, 1'b0, '{16'd0, 1'b0}},
      '{'{-16'sd1, -16'sd1, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd5000, 16'sd5000, 1'b0, 1'b1}, 1'b0, '{16'd0, 1'b0}},
      '{'{16'sd3000, 16'sd4000, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          for (i = 0; i < DIRECTED_ROWS; i++)
            send_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].res);
        end
        1: program_footprint(14'h3FFF, 14'h3FFF, 14'h3FFF, 12'hFFF, 16'hFFFF, 8'hFF);
        2: program_footprint(14'd0, 14'd0, 14'd0, 12'd0, 16'hFFFF, 8'd0);
        3: program_footprint(14'd0, 14'd0, 14'd0, 12'd0, 16'd0, 8'd0);
        4: program_footprint(14'd100, 14'd300, 14'd2000, 12'd0, 16'd20000, 8'd10);
        default: begin
          len = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 3000));
          wid = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 3000));
          wb = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, len));
          mar = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 400));
          maxc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(100, 4000));
          clip = 8'($urandom);
          program_footprint(len, wid, wb, mar, maxc, clip);
        end
      endcase

      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        broken = ($urandom_range(0, 9) == 0);
        reach = int'(swept_radius_of()) + int'(fp_max_clear) / 2 + 64;
        if (reach > 32767) reach = 32767;
        for (k = 0; k < scan_len; k++) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              item.x = CB'($urandom);
              item.y = CB'($urandom);
            end
            2: begin
              item.x = ($urandom_range(0, 1) != 0) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
              item.y = ($urandom_range(0, 1) != 0) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
            end
            default: begin
              item.x = CB'(int'($urandom_range(0, 2 * reach)) - reach);
              item.y = CB'(int'($urandom_range(0, 2 * reach)) - reach);
            end
          endcase
          item.pvalid = ($urandom_range(0, 7) != 0);
          item.last = (k == scan_len - 1) || (broken && $urandom_range(0, 2) == 0);
          send_point(item, 1'b0, '0);
          if (item.pvalid || item.last) phase_items++;
        end
        scans++;
        if (scans % 25 == 0) drain_results();
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_mismatch("results never delivered", awaited_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: turn_in_place_clearance_check_core.f
rtl/tipcc_pkg.sv
rtl/tipcc_if.sv
rtl/tipcc_rss.sv
rtl/turn_in_place_clearance_check_core.sv
dv/turn_in_place_clearance_check_core_test.sv
